@@ sv/assert_macros.svh @@
// Assertion macros used by the drink dispenser top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks a condition at every clock edge outside reset.
`define DDC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Checks that a condition implies another in the same cycle.
`define DDC_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Checks that a condition implies another in the next cycle.
`define DDC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

@@ sv/ddc_pkg.sv @@
// Types and constants of the drink dispenser controller.
package ddc_pkg;

  localparam int PUMP_COUNT = 6;

  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_PLACED   = 3'd1;
  localparam logic [2:0] MODE_DISPENSE = 3'd2;
  localparam logic [2:0] MODE_DELIVER  = 3'd3;
  localparam logic [2:0] MODE_ERROR    = 3'd4;
  localparam logic [2:0] MODE_MAINT    = 3'd5;
  localparam logic [2:0] MODE_CLEAN    = 3'd6;
  localparam logic [2:0] MODE_REFILL   = 3'd7;

  localparam logic [3:0] OP_WEIGHT = 4'd0;
  localparam logic [3:0] OP_BYTE   = 4'd1;
  localparam logic [3:0] OP_RESET  = 4'd2;
  localparam logic [3:0] OP_CANCEL = 4'd3;
  localparam logic [3:0] OP_MAINT  = 4'd4;
  localparam logic [3:0] OP_START  = 4'd5;
  localparam logic [3:0] OP_TIMER  = 4'd6;
  localparam logic [3:0] OP_POT    = 4'd7;
  localparam logic [3:0] OP_TABLE  = 4'd8;

  localparam logic [1:0] TBL_RATIO = 2'd0;
  localparam logic [1:0] TBL_FLOW  = 2'd1;
  localparam logic [1:0] TBL_CAP   = 2'd2;
  localparam logic [1:0] TBL_POT   = 2'd3;

  localparam logic [2:0] CFG_PRESENT  = 3'd0;
  localparam logic [2:0] CFG_DEADBAND = 3'd1;
  localparam logic [2:0] CFG_SMALL    = 3'd2;
  localparam logic [2:0] CFG_MEDIUM   = 3'd3;
  localparam logic [2:0] CFG_BIG      = 3'd4;
  localparam logic [2:0] CFG_TOL      = 3'd5;
  localparam logic [2:0] CFG_ABSENT   = 3'd6;

  localparam logic [3:0] FAULT_NONE    = 4'd0;
  localparam logic [3:0] FAULT_POUR    = 4'd1;
  localparam logic [3:0] FAULT_BAD_CUP = 4'd2;
  localparam logic [3:0] FAULT_CLEAN   = 4'd3;
  localparam logic [3:0] FAULT_PUMP    = 4'd4;

  localparam logic [7:0] SIZE_SMALL  = 8'd120;
  localparam logic [7:0] SIZE_MEDIUM = 8'd190;
  localparam logic [7:0] SIZE_BIG    = 8'd240;

  localparam logic [15:0] CLEAN_LOAD = 16'hFFFF;
  localparam logic [2:0]  VOL_LAT    = 3'd4;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [15:0] weight;
    logic [7:0]         rx_byte;
    logic [9:0]         pot_level;
    logic [1:0]         table_select;
    logic [5:0]         table_index;
    logic [15:0]        table_value;
  } req_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  cup_class;
    logic [3:0]  recipe;
    logic [3:0]  error_code;
    logic [5:0]  pump_enable;
    logic [15:0] timer_load;
    logic        timer_start;
    logic [2:0]  selected_pump;
    logic        maint_choice;
  } rsp_t;

  typedef struct packed {
    logic [3:0]         recipe;
    logic [2:0]         pump;
    logic [1:0]         cup_kind;
    logic signed [15:0] weight;
    logic [9:0]         pot;
    logic [1:0]         tsel;
    logic [5:0]         tidx;
    logic [15:0]        tval;
    logic               tbl_we;
    logic               vol_add;
    logic               clr_one;
    logic               clr_all;
    logic               div_ms;
    logic               div_tk;
  } cmd_t;

  typedef struct packed {
    logic        present_idle;
    logic        below;
    logic [1:0]  cls;
    logic        vol_nz;
    logic        cap_over;
    logic        div_done;
    logic [15:0] tick;
    logic        pot_hit;
    logic [2:0]  pot_pick;
    logic [7:0]  absent_limit;
  } stat_t;

endpackage

@@ sv/ddc_datapath.sv @@
// Datapath: settings, tables, used volumes, cup checks, volume pipeline and divider.
module ddc_datapath import ddc_pkg::*; #(
  parameter int RECIPE_COUNT = 10,
  parameter int TICK_MICROS  = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [14:0] cfg_data,
  input  cmd_t        cmd,
  output stat_t       st
);

  localparam int RATIO_DEPTH = RECIPE_COUNT * PUMP_COUNT;
  localparam int RW = $clog2(RATIO_DEPTH);
  localparam int TK_SHIFT = 26;
  localparam logic [26:0] TK_RECIP = 27'((64'd1 << TK_SHIFT) / 64'(TICK_MICROS));

  logic [14:0] present_level, deadband_level, small_w, medium_w, big_w, tolerance;
  logic [7:0]  absent_limit;

  logic [7:0]  ratio_mem [RATIO_DEPTH];
  logic [15:0] flow_rate [PUMP_COUNT];
  logic [15:0] capacity [PUMP_COUNT];
  logic [9:0]  pot_bound [PUMP_COUNT + 1];
  logic [15:0] used_volume [PUMP_COUNT];

  logic [7:0]  ratio_q;
  logic [15:0] prod_q, prod_d;
  logic [9:0]  q0_q;
  logic [9:0]  vol;

  logic        div_busy;
  logic [4:0]  div_cnt;
  logic [15:0] div_rem;
  logic [25:0] div_quo;
  logic [15:0] div_dvs;

  logic [25:0] tk_num;
  logic [25:0] tk_q0;
  logic [25:0] tk_quo;
  logic [1:0]  tk_stage;
  logic [52:0] tk_prod;
  logic [25:0] tk_rem;

  logic [7:0]  rd_full;
  logic [RW-1:0] rd_addr;
  logic [7:0]  size;
  logic [16:0] rem_sh;
  logic        rem_ge;
  logic [16:0] vol_diff;

  always_comb begin
    rd_full = 8'(cmd.recipe) * 8'(PUMP_COUNT) + 8'(cmd.pump);
    rd_addr = rd_full[RW-1:0];
    unique case (cmd.cup_kind)
      2'd1: size = SIZE_SMALL;
      2'd2: size = SIZE_MEDIUM;
      2'd3: size = SIZE_BIG;
      default: size = 8'd0;
    endcase
    vol_diff = 17'(prod_d) - 17'(q0_q) * 17'd100;
    rem_sh = {div_rem, div_quo[25]};
    rem_ge = rem_sh >= {1'b0, div_dvs};
    tk_prod = 53'(tk_num) * 53'(TK_RECIP);
    tk_rem  = tk_num - tk_q0 * 26'(TICK_MICROS);
  end

  // Settings registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      present_level  <= 15'd20;
      deadband_level <= 15'd3;
      small_w        <= 15'd30;
      medium_w       <= 15'd45;
      big_w          <= 15'd60;
      tolerance      <= 15'd5;
      absent_limit   <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PRESENT:  present_level  <= cfg_data;
        CFG_DEADBAND: deadband_level <= cfg_data;
        CFG_SMALL:    small_w        <= cfg_data;
        CFG_MEDIUM:   medium_w       <= cfg_data;
        CFG_BIG:      big_w          <= cfg_data;
        CFG_TOL:      tolerance      <= cfg_data;
        CFG_ABSENT:   absent_limit   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Tables; the ratio table is a memory with a registered read.
  always_ff @(posedge clk) begin
    ratio_q <= ratio_mem[rd_addr];
    if (cmd.tbl_we) begin
      unique case (cmd.tsel)
        TBL_RATIO: if (7'(cmd.tidx) < 7'(RATIO_DEPTH))
          ratio_mem[RW'(cmd.tidx)] <= cmd.tval[7:0];
        TBL_FLOW: if (7'(cmd.tidx) < 7'(PUMP_COUNT))
          flow_rate[cmd.tidx[2:0]] <= cmd.tval;
        TBL_CAP: if (7'(cmd.tidx) < 7'(PUMP_COUNT))
          capacity[cmd.tidx[2:0]] <= cmd.tval;
        TBL_POT: if (7'(cmd.tidx) <= 7'(PUMP_COUNT))
          pot_bound[cmd.tidx[2:0]] <= cmd.tval[9:0];
        default: ;
      endcase
    end
  end

  // Volume pipeline: size times ratio, then division by 100 by reciprocal.
  always_ff @(posedge clk) begin
    prod_q <= 16'(size) * 16'(ratio_q);
    prod_d <= prod_q;
    q0_q   <= 10'((29'(prod_q) * 29'd5242) >> 19);
    vol    <= (vol_diff >= 17'd100) ? q0_q + 10'd1 : q0_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PUMP_COUNT; i++) used_volume[i] <= 16'd0;
    end else if (cmd.clr_all) begin
      for (int i = 0; i < PUMP_COUNT; i++) used_volume[i] <= 16'd0;
    end else if (cmd.clr_one) begin
      used_volume[cmd.pump] <= 16'd0;
    end else if (cmd.vol_add) begin
      used_volume[cmd.pump] <= used_volume[cmd.pump] + 16'(vol);
    end
  end

  // Restoring divider for the flow rate, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= 5'd0;
    end else if (cmd.div_ms) begin
      div_rem <= 16'd0;
      div_dvs <= flow_rate[cmd.pump];
      div_cnt <= 5'd26;
      if (flow_rate[cmd.pump] == 16'd0) begin
        div_quo  <= 26'hFFFF;
        div_busy <= 1'b0;
      end else begin
        div_quo  <= 26'(vol) * 26'd100000;
        div_busy <= 1'b1;
      end
    end else if (div_busy) begin
      div_rem <= rem_ge ? 16'(rem_sh - {1'b0, div_dvs}) : rem_sh[15:0];
      div_quo <= {div_quo[24:0], rem_ge};
      div_cnt <= div_cnt - 5'd1;
      if (div_cnt == 5'd1) div_busy <= 1'b0;
    end
  end

  // Tick scaling by reciprocal multiplication with one correction step.
  always_ff @(posedge clk) begin
    if (rst) begin
      tk_stage <= 2'd0;
    end else begin
      tk_stage <= {tk_stage[0], cmd.div_tk};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_tk) tk_num <= 26'(div_quo[15:0]) * 26'd1000;
    tk_q0  <= 26'(tk_prod >> TK_SHIFT);
    tk_quo <= (tk_rem >= 26'(TICK_MICROS)) ? tk_q0 + 26'd1 : tk_q0;
  end

  logic signed [17:0] w18, w_idle, lvl, db, tol18;
  logic signed [17:0] sm, md, bg;

  always_comb begin
    w18   = 18'(cmd.weight);
    lvl   = 18'(present_level);
    db    = 18'(deadband_level);
    tol18 = 18'(tolerance);
    sm    = 18'(small_w);
    md    = 18'(medium_w);
    bg    = 18'(big_w);
    w_idle = (w18 < db && w18 > -db) ? 18'sd0 : w18;
    st = '0;
    st.present_idle = w_idle > lvl;
    st.below        = w18 < lvl;
    if (w18 >= sm - tol18 && w18 <= sm + tol18)      st.cls = 2'd1;
    else if (w18 >= md - tol18 && w18 <= md + tol18) st.cls = 2'd2;
    else if (w18 >= bg - tol18 && w18 <= bg + tol18) st.cls = 2'd3;
    else                                             st.cls = 2'd0;
    st.vol_nz   = vol != 10'd0;
    st.cap_over = 17'(used_volume[cmd.pump]) + 17'(vol) > 17'(capacity[cmd.pump]);
    st.div_done = !div_busy && tk_stage == 2'd0;
    st.tick     = tk_quo[15:0] - 16'd1;
    for (int i = PUMP_COUNT; i >= 0; i--) begin
      if (cmd.pot <= pot_bound[i]) begin
        st.pot_hit  = 1'b1;
        st.pot_pick = 3'(i);
      end
    end
    st.absent_limit = absent_limit;
  end

endmodule

@@ sv/ddc_ctrl.sv @@
// Controller: request sequencing, dispenser modes and the result register.
module ddc_ctrl import ddc_pkg::*; #(
  parameter int RECIPE_COUNT = 10
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  req_t  req,
  output logic  rsp_valid,
  input  logic  rsp_ready,
  output rsp_t  rsp,
  output cmd_t  cmd,
  input  stat_t st
);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_CAP, S_RUN, S_ADD, S_MS_GO, S_MS_WAIT, S_TK_GO, S_TK_WAIT, S_DONE
  } seq_t;

  seq_t        seq;
  req_t        req_q;
  logic [2:0]  mode;
  logic [1:0]  cup_kind;
  logic [3:0]  recipe;
  logic [3:0]  fault;
  logic [2:0]  active;
  logic [7:0]  absent;
  logic        mpick;
  logic [2:0]  ppick;
  logic [15:0] t_load;
  logic        t_start;
  logic [2:0]  pidx;
  logic [2:0]  wait_cnt;

  logic [7:0]  cnt_inc;
  logic        gone;
  logic        byte_ok;
  logic [3:0]  byte_rec;
  logic [5:0]  enable;
  logic        last_pump;

  assign req_ready = seq == S_IDLE;
  assign last_pump = pidx == 3'(PUMP_COUNT - 1);

  always_comb begin
    cnt_inc = (absent == 8'd255) ? absent : absent + 8'd1;
    gone = st.below && cnt_inc >= st.absent_limit;
    byte_ok = 1'b0;
    byte_rec = 4'd0;
    if (req_q.rx_byte >= "1" && req_q.rx_byte <= "9") begin
      byte_ok = 1'b1;
      byte_rec = 4'(req_q.rx_byte - "1");
    end else if (req_q.rx_byte == "A") begin
      byte_ok = 1'b1;
      byte_rec = 4'd9;
    end
    if (5'(byte_rec) >= 5'(RECIPE_COUNT)) byte_ok = 1'b0;
    enable = 6'd0;
    if (mode == MODE_DISPENSE) enable = 6'(1) << active;
    else if (mode == MODE_CLEAN)
      enable = (4'(ppick) >= 4'(PUMP_COUNT)) ? 6'h3F : 6'(1) << ppick;
  end

  always_comb begin
    cmd = '0;
    cmd.recipe   = recipe;
    cmd.pump     = (seq == S_EXEC) ? ppick : pidx;
    cmd.cup_kind = cup_kind;
    cmd.weight   = req_q.weight;
    cmd.pot      = req_q.pot_level;
    cmd.tsel     = req_q.table_select;
    cmd.tidx     = req_q.table_index;
    cmd.tval     = req_q.table_value;
    if (seq == S_EXEC) begin
      cmd.tbl_we = req_q.opcode == OP_TABLE;
      if (req_q.opcode == OP_START && mode == MODE_MAINT && mpick) begin
        cmd.clr_all = 4'(ppick) >= 4'(PUMP_COUNT);
        cmd.clr_one = 4'(ppick) < 4'(PUMP_COUNT);
      end
    end
    cmd.vol_add = seq == S_ADD && wait_cnt == VOL_LAT;
    cmd.div_ms  = seq == S_MS_GO;
    cmd.div_tk  = seq == S_TK_GO;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= S_IDLE;
      mode      <= MODE_IDLE;
      cup_kind  <= 2'd0;
      recipe    <= 4'd0;
      fault     <= FAULT_NONE;
      active    <= 3'd0;
      absent    <= 8'd0;
      mpick     <= 1'b0;
      ppick     <= 3'd0;
      pidx      <= 3'd0;
      wait_cnt  <= 3'd0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && seq != S_DONE) rsp_valid <= 1'b0;
      unique case (seq)
        S_IDLE: begin
          if (req_valid) begin
            req_q   <= req;
            t_load  <= 16'd0;
            t_start <= 1'b0;
            seq     <= S_EXEC;
          end
        end
        S_EXEC: begin
          seq <= S_DONE;
          unique case (req_q.opcode)
            OP_WEIGHT: begin
              unique case (mode)
                MODE_IDLE: if (st.present_idle) mode <= MODE_PLACED;
                MODE_PLACED: begin
                  if (st.below) begin
                    cup_kind <= 2'd0;
                    mode <= MODE_IDLE;
                  end else begin
                    cup_kind <= st.cls;
                  end
                end
                MODE_DISPENSE: begin
                  absent <= st.below ? cnt_inc : 8'd0;
                  if (gone) begin
                    active <= 3'd0;
                    ppick  <= 3'd0;
                    absent <= 8'd0;
                    fault  <= FAULT_POUR;
                    mode   <= MODE_ERROR;
                  end
                end
                MODE_CLEAN: begin
                  absent <= st.below ? cnt_inc : 8'd0;
                  if (gone) begin
                    cup_kind <= 2'd0;
                    recipe   <= 4'd0;
                    ppick    <= 3'd0;
                    absent   <= 8'd0;
                    fault    <= FAULT_CLEAN;
                    mode     <= MODE_ERROR;
                  end
                end
                MODE_DELIVER: begin
                  if (st.below) begin
                    cup_kind <= 2'd0;
                    recipe   <= 4'd0;
                    mode     <= MODE_IDLE;
                  end
                end
                default: ;
              endcase
            end
            OP_BYTE: begin
              if (mode == MODE_PLACED && byte_ok) begin
                recipe <= byte_rec;
                if (cup_kind == 2'd0) begin
                  fault <= FAULT_BAD_CUP;
                  mode  <= MODE_ERROR;
                end else begin
                  mode     <= MODE_DISPENSE;
                  pidx     <= 3'd0;
                  wait_cnt <= 3'd0;
                  seq      <= S_CAP;
                end
              end
            end
            OP_RESET, OP_CANCEL: begin
              if (req_q.opcode == OP_RESET || mode == MODE_DISPENSE || mode == MODE_CLEAN)
              begin
                cup_kind <= 2'd0;
                recipe   <= 4'd0;
                fault    <= FAULT_NONE;
                mode     <= MODE_IDLE;
                mpick    <= 1'b0;
                ppick    <= 3'd0;
                absent   <= 8'd0;
                active   <= 3'd0;
              end
            end
            OP_MAINT: begin
              if (mode == MODE_IDLE || mode == MODE_PLACED) begin
                mpick <= 1'b0;
                mode  <= MODE_MAINT;
              end else if (mode == MODE_MAINT) begin
                mpick <= ~mpick;
              end
            end
            OP_START: begin
              if (mode == MODE_MAINT) begin
                if (!mpick) begin
                  mode    <= MODE_CLEAN;
                  absent  <= 8'd0;
                  t_load  <= CLEAN_LOAD;
                  t_start <= 1'b1;
                end else begin
                  ppick <= 3'd0;
                  mode  <= MODE_IDLE;
                end
                mpick <= 1'b0;
              end
            end
            OP_TIMER: begin
              if (mode == MODE_DISPENSE) begin
                pidx     <= active;
                wait_cnt <= 3'd0;
                seq      <= S_ADD;
              end else if (mode == MODE_CLEAN) begin
                ppick <= 3'd0;
                mode  <= MODE_IDLE;
              end
            end
            OP_POT: if (mode == MODE_MAINT && st.pot_hit) ppick <= st.pot_pick;
            default: ;
          endcase
        end
        S_CAP: begin
          wait_cnt <= wait_cnt + 3'd1;
          if (wait_cnt == VOL_LAT) begin
            wait_cnt <= 3'd0;
            if (st.vol_nz && st.cap_over) begin
              fault <= FAULT_PUMP + 4'(pidx);
              mode  <= MODE_ERROR;
              seq   <= S_DONE;
            end else if (last_pump) begin
              pidx <= 3'd0;
              seq  <= S_RUN;
            end else begin
              pidx <= pidx + 3'd1;
            end
          end
        end
        S_RUN: begin
          wait_cnt <= wait_cnt + 3'd1;
          if (wait_cnt == VOL_LAT) begin
            wait_cnt <= 3'd0;
            if (st.vol_nz) begin
              active <= pidx;
              absent <= 8'd0;
              seq    <= S_MS_GO;
            end else if (last_pump) begin
              active <= 3'd0;
              ppick  <= 3'd0;
              mode   <= MODE_DELIVER;
              seq    <= S_DONE;
            end else begin
              pidx <= pidx + 3'd1;
            end
          end
        end
        S_ADD: begin
          wait_cnt <= wait_cnt + 3'd1;
          if (wait_cnt == VOL_LAT) begin
            wait_cnt <= 3'd0;
            if (last_pump) begin
              active <= 3'd0;
              ppick  <= 3'd0;
              mode   <= MODE_DELIVER;
              seq    <= S_DONE;
            end else begin
              pidx <= pidx + 3'd1;
              seq  <= S_RUN;
            end
          end
        end
        S_MS_GO: seq <= S_MS_WAIT;
        S_MS_WAIT: if (st.div_done) seq <= S_TK_GO;
        S_TK_GO: seq <= S_TK_WAIT;
        S_TK_WAIT: begin
          if (st.div_done) begin
            t_load  <= st.tick;
            t_start <= 1'b1;
            seq     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.mode          <= mode;
            rsp.cup_class     <= cup_kind;
            rsp.recipe        <= recipe;
            rsp.error_code    <= fault;
            rsp.pump_enable   <= enable;
            rsp.timer_load    <= t_load;
            rsp.timer_start   <= t_start;
            rsp.selected_pump <= ppick;
            rsp.maint_choice  <= mpick;
            rsp_valid         <= 1'b1;
            seq               <= S_IDLE;
          end
        end
        default: seq <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/drink_dispenser_controller.sv @@
// Most requests pass through S_EXEC and S_DONE before a valid result is registered.
// A pour start walks the pumps through S_CAP and S_RUN, runs a 26-step division and
// the tick scaling; a timer done in dispense adds the volume and walks on from S_ADD.
// One request is in work at a time; the next is accepted while a result waits.
// Throughput is set by the pump walk and the serial divider.
// Synchronous reset returns all modes, counters and settings to their defaults.
module drink_dispenser_controller import ddc_pkg::*; #(
  parameter int RECIPE_COUNT = 10,
  parameter int TICK_MICROS  = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [14:0] cfg_data
);

`include "assert_macros.svh"

  cmd_t  cmd;
  stat_t st;

  ddc_ctrl #(.RECIPE_COUNT(RECIPE_COUNT)) u_ctrl (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cmd(cmd), .st(st)
  );

  ddc_datapath #(.RECIPE_COUNT(RECIPE_COUNT), .TICK_MICROS(TICK_MICROS)) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .cmd(cmd), .st(st)
  );

  `DDC_ASSERT_NEXT(a_one_request, req_valid && req_ready, !req_ready, "second request taken early")
  `DDC_ASSERT(a_no_refill_held, !rsp_valid || rsp.mode != MODE_REFILL, "refill mode reported")
  `DDC_ASSERT_IMPL(a_pumps_off, rsp_valid && rsp.mode != MODE_DISPENSE && rsp.mode != MODE_CLEAN, rsp.pump_enable == 6'd0, "pump driven outside pour or clean")
  `DDC_ASSERT_IMPL(a_timer_mode, rsp_valid && rsp.timer_start, rsp.mode == MODE_DISPENSE || rsp.mode == MODE_CLEAN, "timer started in wrong mode")
  `DDC_ASSERT_IMPL(a_one_pump, rsp_valid && rsp.mode == MODE_DISPENSE, $onehot(rsp.pump_enable), "pour drives other than one pump")

endmodule
